// ===== hw/rtl/alt_pkg.sv =====
// Shared types, constants and controller/datapath interface for the list engine.
`default_nettype none

package alt_pkg;

  localparam int CAPACITY = 256;
  localparam int WORD_W   = 32;
  localparam int KIND_W   = 3;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ    = 3'd0,
    KIND_SEARCH  = 3'd1,
    KIND_INSERT  = 3'd2,
    KIND_REMOVE  = 3'd3,
    KIND_REPLACE = 3'd4
  } kind_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;        // capture the incoming word
    logic rd_single;   // single read for a read operation
    logic start_scan;  // set up the pointer for a walk
    logic step;        // advance the walk by one entry
    logic put;         // write the operand at the position
    logic drop;        // shrink the list by one
    logic finish;      // register the result and strobe it
  } alt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    kind_t kind;
    logic  legal;
    logic  scan_end;
  } alt_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/alt_ctrl.sv =====
// Sequencing state machine of the list engine.
`default_nettype none

module alt_ctrl import alt_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire alt_stat_t stat,
  output alt_cmd_t       cmd,
  output logic           busy
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DECODE = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt = ST_FINISH;
        case (stat.kind)
          KIND_READ: begin
            cmd.rd_single = stat.legal;
          end
          KIND_SEARCH: begin
            cmd.start_scan = 1'b1;
            state_nxt      = ST_SCAN;
          end
          KIND_INSERT, KIND_REMOVE: begin
            if (stat.legal) begin
              cmd.start_scan = 1'b1;
              state_nxt      = ST_SCAN;
            end
          end
          KIND_REPLACE: begin
            cmd.put = stat.legal;
          end
          default: begin
            state_nxt = ST_FINISH;
          end
        endcase
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (stat.scan_end) begin
          cmd.put   = (stat.kind == KIND_INSERT);
          cmd.drop  = (stat.kind == KIND_REMOVE);
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/alt_dp.sv =====
// Datapath of the list engine: entry memory, count, walk pointer and result registers.
`default_nettype none

module alt_dp import alt_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CNT_W-1:0]  cfg_wdata,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire logic [CNT_W-1:0]  in_position,
  input  wire word_t             in_value,
  input  wire alt_cmd_t          cmd,
  output alt_stat_t              stat,
  output logic                   out_valid,
  output logic                   out_ok,
  output word_t                  out_read_value,
  output logic [CNT_W-1:0]       out_found_at,
  output logic [CNT_W-1:0]       out_count,
  output logic                   out_is_empty,
  output logic                   out_is_full
);

  localparam cnt_t CAP_MAX = CNT_W'(CAPACITY);
  localparam cnt_t CNT_ONE = CNT_W'(1);

  word_t mem [CAPACITY];
  word_t rdata_r;

  cnt_t  cap_r, cnt_r, pos_r, ptr_r, ptr_nxt;
  kind_t kind_r;
  word_t word_r;
  logic  pend_r, pend_nxt;
  addr_t pidx_r, pidx_nxt;
  logic  ok_r;
  cnt_t  found_r;

  logic  out_valid_r, out_ok_r, out_empty_r, out_full_r;
  word_t out_rv_r;
  cnt_t  out_found_r, out_count_r;

  cnt_t  lim;
  logic  match;
  logic  rd_en, wr_en;
  addr_t rd_addr, wr_addr;
  word_t wr_data;

  // Clamp the capacity limit to one..CAPACITY
  always_comb begin
    if (cap_r == '0) begin
      lim = CNT_ONE;
    end else if (cap_r > CAP_MAX) begin
      lim = CAP_MAX;
    end else begin
      lim = cap_r;
    end
  end

  assign match = pend_r && (rdata_r == word_r);

  always_comb begin
    stat.kind     = kind_r;
    stat.legal    = 1'b0;
    stat.scan_end = 1'b0;
    case (kind_r)
      KIND_READ: begin
        stat.legal = (cnt_r != '0);
      end
      KIND_SEARCH: begin
        stat.legal    = 1'b1;
        stat.scan_end = match || (!pend_r && (ptr_r >= cnt_r));
      end
      KIND_INSERT: begin
        stat.legal    = (pos_r <= cnt_r) && (cnt_r < lim);
        stat.scan_end = !pend_r && (ptr_r == pos_r);
      end
      KIND_REMOVE: begin
        stat.legal    = (pos_r < cnt_r);
        stat.scan_end = !pend_r && (ptr_r >= cnt_r);
      end
      KIND_REPLACE: begin
        stat.legal = (pos_r < cnt_r);
      end
      default: begin
        stat.legal = 1'b0;
      end
    endcase
  end

  // Memory port control and walk pointer
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_data  = rdata_r;
    ptr_nxt  = ptr_r;
    pend_nxt = pend_r;
    pidx_nxt = pidx_r;
    if (cmd.start_scan) begin
      pend_nxt = 1'b0;
      case (kind_r)
        KIND_INSERT: ptr_nxt = cnt_r;
        KIND_REMOVE: ptr_nxt = pos_r + CNT_ONE;
        default:     ptr_nxt = '0;
      endcase
    end
    if (cmd.rd_single) begin
      rd_en   = 1'b1;
      rd_addr = (pos_r < cnt_r) ? pos_r[ADDR_W-1:0] : ADDR_W'(cnt_r - CNT_ONE);
    end
    if (cmd.step) begin
      pend_nxt = 1'b0;
      case (kind_r)
        KIND_SEARCH: begin
          if (ptr_r < cnt_r) begin
            rd_en    = 1'b1;
            rd_addr  = ptr_r[ADDR_W-1:0];
            pidx_nxt = ptr_r[ADDR_W-1:0];
            pend_nxt = 1'b1;
            ptr_nxt  = ptr_r + CNT_ONE;
          end
        end
        KIND_INSERT: begin
          // move the entry read last cycle up by one
          if (pend_r) begin
            wr_en   = 1'b1;
            wr_addr = pidx_r + 1'b1;
          end
          if (ptr_r > pos_r) begin
            rd_en    = 1'b1;
            rd_addr  = ADDR_W'(ptr_r - CNT_ONE);
            pidx_nxt = ADDR_W'(ptr_r - CNT_ONE);
            pend_nxt = 1'b1;
            ptr_nxt  = ptr_r - CNT_ONE;
          end
        end
        KIND_REMOVE: begin
          // move the entry read last cycle down by one
          if (pend_r) begin
            wr_en   = 1'b1;
            wr_addr = pidx_r - 1'b1;
          end
          if (ptr_r < cnt_r) begin
            rd_en    = 1'b1;
            rd_addr  = ptr_r[ADDR_W-1:0];
            pidx_nxt = ptr_r[ADDR_W-1:0];
            pend_nxt = 1'b1;
            ptr_nxt  = ptr_r + CNT_ONE;
          end
        end
        default: begin
          pend_nxt = 1'b0;
        end
      endcase
    end
    if (cmd.put) begin
      wr_en   = 1'b1;
      wr_addr = pos_r[ADDR_W-1:0];
      wr_data = word_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    ptr_r  <= ptr_nxt;
    pidx_r <= pidx_nxt;
    if (cmd.load) begin
      kind_r <= kind_t'(in_kind);
      pos_r  <= in_position;
      word_r <= in_value;
    end
    if (cmd.step && (kind_r == KIND_SEARCH) && match) begin
      found_r <= CNT_W'(pidx_r);
    end
    if (cmd.finish) begin
      out_ok_r    <= ok_r;
      out_rv_r    <= ((kind_r == KIND_READ) && (cnt_r != '0)) ? rdata_r : '0;
      out_found_r <= (kind_r != KIND_SEARCH) ? '0 : (ok_r ? found_r : cnt_r);
      out_count_r <= cnt_r;
      out_empty_r <= (cnt_r == '0);
      out_full_r  <= (cnt_r >= lim);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_MAX;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      ok_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      pend_r      <= pend_nxt;
      out_valid_r <= cmd.finish;
      if (cmd.put && (kind_r == KIND_INSERT)) begin
        cnt_r <= cnt_r + CNT_ONE;
      end else if (cmd.drop) begin
        cnt_r <= cnt_r - CNT_ONE;
      end
      if (cmd.load) begin
        ok_r <= 1'b0;
      end else if (cmd.put || cmd.drop ||
                   (cmd.rd_single && (pos_r < cnt_r)) ||
                   (cmd.step && (kind_r == KIND_SEARCH) && match)) begin
        ok_r <= 1'b1;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_read_value = out_rv_r;
  assign out_found_at   = out_found_r;
  assign out_count      = out_count_r;
  assign out_is_empty   = out_empty_r;
  assign out_is_full    = out_full_r;

endmodule

`default_nettype wire

// ===== hw/rtl/array_list_table_engine_unit.sv =====
// Top level of the ordered list engine: controller plus datapath.
`default_nettype none

// Ordered list of signed 32-bit entries held in a 256-entry single-port-write,
// single-port-read memory with registered read data.
// Input: present in_kind, in_position and in_value with start; the word is
// taken at a rising edge where start is high and busy is low. Busy stays high
// until the operation has finished.
// Result: one word per input, shown for exactly one cycle with out_valid high.
// The receiver cannot stall; it must take the word in that cycle.
// Configuration: cfg_we with cfg_wdata sets the capacity limit (clamped to
// 1..256); write it only while the block is idle.
// Walk through the entries, by kind:
//   read, replace, failed insert/remove, unused kinds: no walk
//   search: walks up from index 0 until a hit or the end of the list
//   insert: walks down from the count to the position, moving entries up
//   remove: walks up from position + 1 to the count, moving entries down
// The next word can be taken at the edge that takes the result, not before.
// The walk moves one entry per cycle through the memory's one read and one
// write port, in the kinds that walk.
// Reset (synchronous, rst_n low): count cleared, limit back to 256. The
// entry memory is not cleared; entries beyond the count are never read.
module array_list_table_engine_unit import alt_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire logic [CNT_W-1:0]  in_position,
  input  wire word_t             in_value,
  input  wire logic              cfg_we,
  input  wire logic [CNT_W-1:0]  cfg_wdata,
  output logic                   out_valid,
  output logic                   out_ok,
  output word_t                  out_read_value,
  output logic [CNT_W-1:0]       out_found_at,
  output logic [CNT_W-1:0]       out_count,
  output logic                   out_is_empty,
  output logic                   out_is_full
);

  alt_cmd_t  cmd;
  alt_stat_t stat;

  // Sequence each operation: decode, walk, finish
  alt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Hold the entries, count and result registers
  alt_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_kind        (in_kind),
    .in_position    (in_position),
    .in_value       (in_value),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_ok         (out_ok),
    .out_read_value (out_read_value),
    .out_found_at   (out_found_at),
    .out_count      (out_count),
    .out_is_empty   (out_is_empty),
    .out_is_full    (out_is_full)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/alt_chk.sv =====
// Port-level checker for the list engine, bound to the top level.
`default_nettype none

module alt_chk import alt_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire logic              out_ok,
  input wire logic [CNT_W-1:0]  out_found_at,
  input wire logic [CNT_W-1:0]  out_count,
  input wire logic              out_is_empty
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CAPACITY);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted word");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_count == '0)))
    else $error("empty flag disagrees with count");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count <= CNT_MAX))
    else $error("count beyond capacity");

  a_fail_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> ((out_found_at == '0) || (out_found_at == out_count)))
    else $error("failed result carries a stray position");

endmodule

bind array_list_table_engine_unit alt_chk u_alt_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_ok       (out_ok),
  .out_found_at (out_found_at),
  .out_count    (out_count),
  .out_is_empty (out_is_empty)
);

`default_nettype wire
